[rtl/lpfd_pkg.sv]
`default_nettype none

package lpfd_pkg;

  typedef enum logic [3:0] {
    PH_PREFIX  = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_HALTED  = 4'b1000
  } lpfd_phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_HEADER  = 2'd2;
  localparam logic [1:0] ERR_PAYLOAD = 2'd3;

  localparam logic [1:0] REG_FRAME_MAGIC  = 2'd0;
  localparam logic [1:0] REG_WIRE_VERSION = 2'd1;
  localparam logic [1:0] REG_MAX_HEADER   = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

  localparam logic [31:0] RST_FRAME_MAGIC  = 32'h0000_0000;
  localparam logic [31:0] RST_WIRE_VERSION = 32'h0000_0001;
  localparam logic [31:0] RST_MAX_HEADER   = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_MAX_PAYLOAD  = 32'hFFFF_FFFF;

  // prefix byte positions (count before increment) at which a word completes
  localparam logic [3:0] POS_MAGIC   = 4'd3;
  localparam logic [3:0] POS_VERSION = 4'd7;
  localparam logic [3:0] POS_HEADER  = 4'd11;
  localparam logic [3:0] POS_PAYLOAD = 4'd15;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [1:0] error_code;
  } lpfd_result_t;

endpackage

`default_nettype wire

[rtl/lpfd_front.sv]
`default_nettype none

module lpfd_front
  import lpfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         byte_acc,
  input  wire logic [7:0]   data_byte,
  output lpfd_result_t      res,
  output logic              res_valid
);

  logic [31:0] frame_magic_r, wire_version_r, max_header_r, max_payload_r;

  lpfd_phase_t phase_r, phase_nxt;
  logic [3:0]  prefix_count_r, prefix_count_nxt;
  logic [31:0] word_shift_r, word_shift_nxt;
  logic        magic_bad_r, magic_bad_nxt;
  logic        version_bad_r, version_bad_nxt;
  logic [31:0] header_len_r, header_len_nxt;
  logic [31:0] payload_len_r, payload_len_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic        first_pending_r, first_pending_nxt;

  logic [31:0] shifted;
  logic [31:0] left_dec;

  assign shifted  = {word_shift_r[23:0], data_byte};
  assign left_dec = bytes_left_r - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_magic_r  <= RST_FRAME_MAGIC;
      wire_version_r <= RST_WIRE_VERSION;
      max_header_r   <= RST_MAX_HEADER;
      max_payload_r  <= RST_MAX_PAYLOAD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_MAGIC:  frame_magic_r  <= cfg_data;
        REG_WIRE_VERSION: wire_version_r <= cfg_data;
        REG_MAX_HEADER:   max_header_r   <= cfg_data;
        REG_MAX_PAYLOAD:  max_payload_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    prefix_count_nxt  = prefix_count_r;
    word_shift_nxt    = word_shift_r;
    magic_bad_nxt     = magic_bad_r;
    version_bad_nxt   = version_bad_r;
    header_len_nxt    = header_len_r;
    payload_len_nxt   = payload_len_r;
    bytes_left_nxt    = bytes_left_r;
    first_pending_nxt = first_pending_r;
    res_valid         = 1'b0;
    res               = '0;

    if (byte_acc) begin
      unique case (phase_r)
        PH_HEADER, PH_PAYLOAD: begin
          res_valid            = 1'b1;
          res.kind             = (phase_r == PH_HEADER) ? KIND_HEADER : KIND_PAYLOAD;
          res.body_byte        = data_byte;
          res.first_of_frame   = first_pending_r;
          first_pending_nxt    = 1'b0;
          bytes_left_nxt       = left_dec;
          if (left_dec == 32'd0) begin
            if (phase_r == PH_HEADER && payload_len_r != 32'd0) begin
              phase_nxt      = PH_PAYLOAD;
              bytes_left_nxt = payload_len_r;
            end else begin
              phase_nxt         = PH_PREFIX;
              res.last_of_frame = 1'b1;
            end
          end
        end
        PH_HALTED: ;
        PH_PREFIX: begin
          word_shift_nxt   = shifted;
          prefix_count_nxt = prefix_count_r + 4'd1;
          unique case (prefix_count_r)
            POS_MAGIC:   magic_bad_nxt   = (shifted != frame_magic_r);
            POS_VERSION: version_bad_nxt = (shifted != wire_version_r);
            POS_HEADER:  header_len_nxt  = shifted;
            POS_PAYLOAD: begin
              payload_len_nxt = shifted;
              word_shift_nxt  = '0;
              magic_bad_nxt   = 1'b0;
              version_bad_nxt = 1'b0;
              priority if (magic_bad_r) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_MAGIC;
                phase_nxt      = PH_HALTED;
              end else if (version_bad_r) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_VERSION;
                phase_nxt      = PH_HALTED;
              end else if (header_len_r > max_header_r) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_HEADER;
                phase_nxt      = PH_HALTED;
              end else if (shifted > max_payload_r) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_PAYLOAD;
                phase_nxt      = PH_HALTED;
              end else if (header_len_r == 32'd0 && shifted == 32'd0) begin
                res_valid          = 1'b1;
                res.kind           = KIND_EMPTY;
                res.first_of_frame = 1'b1;
                res.last_of_frame  = 1'b1;
              end else if (header_len_r != 32'd0) begin
                first_pending_nxt = 1'b1;
                phase_nxt         = PH_HEADER;
                bytes_left_nxt    = header_len_r;
              end else begin
                first_pending_nxt = 1'b1;
                phase_nxt         = PH_PAYLOAD;
                bytes_left_nxt    = shifted;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_PREFIX;
      prefix_count_r  <= '0;
      word_shift_r    <= '0;
      magic_bad_r     <= 1'b0;
      version_bad_r   <= 1'b0;
      header_len_r    <= '0;
      payload_len_r   <= '0;
      bytes_left_r    <= '0;
      first_pending_r <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      prefix_count_r  <= prefix_count_nxt;
      word_shift_r    <= word_shift_nxt;
      magic_bad_r     <= magic_bad_nxt;
      version_bad_r   <= version_bad_nxt;
      header_len_r    <= header_len_nxt;
      payload_len_r   <= payload_len_nxt;
      bytes_left_r    <= bytes_left_nxt;
      first_pending_r <= first_pending_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lpfd_queue.sv]
`default_nettype none

module lpfd_queue
  import lpfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lpfd_result_t  push_data,
  input  wire logic          pop,
  output lpfd_result_t       head,
  output logic               empty,
  output logic               full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpfd_result_t        mem_r [DEPTH];
  logic [AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]       count_r;
  logic                do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/lpfd_back.sv]
`default_nettype none

module lpfd_back
  import lpfd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire lpfd_result_t  q_head,
  output logic               q_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output lpfd_result_t       out_res
);

  logic         valid_r;
  lpfd_result_t res_r;

  assign q_pop     = !q_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/length_prefixed_frame_decoder.sv]
// channel   ports                          transaction when
// input     in_push in_full in_data_byte   in_push && !in_full
// result    out_pop out_empty out_*        out_pop && !out_empty
// config    cfg_valid cfg_ready cfg_*      cfg_valid && cfg_ready (ready tied high)
//
// One byte per clock unless in_full; results pass the queue, then the output register.
// in_full is the queue's full flag (output register then occupied if depth > 1).
// Reset is synchronous: parse state and queue cleared, registers to defaults.
// Bytes after an error are taken and dropped until reset.
`default_nettype none

module length_prefixed_frame_decoder
  import lpfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic [7:0]   in_data_byte,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_body_byte,
  output logic              out_first_of_frame,
  output logic              out_last_of_frame,
  output logic [1:0]        out_error_code,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  lpfd_result_t front_res, q_head, out_res;
  logic         front_valid, byte_acc;
  logic         q_empty, q_full, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign byte_acc  = in_push && !q_full;

  lpfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_acc  (byte_acc),
    .data_byte (in_data_byte),
    .res       (front_res),
    .res_valid (front_valid)
  );

  lpfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_acc && front_valid),
    .push_data (front_res),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  lpfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_body_byte      = out_res.body_byte;
  assign out_first_of_frame = out_res.first_of_frame;
  assign out_last_of_frame  = out_res.last_of_frame;
  assign out_error_code     = out_res.error_code;

endmodule

`default_nettype wire

[rtl/lpfd_checker.sv]
`default_nettype none

module lpfd_checker
  import lpfd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_body_byte,
  input wire logic        out_first_of_frame,
  input wire logic        out_last_of_frame,
  input wire logic [1:0]  out_error_code
);

  a_empty_frame_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_EMPTY) |->
      (out_first_of_frame && out_last_of_frame && out_body_byte == 8'd0
       && out_error_code == ERR_MAGIC))
    else $error("empty-frame result with wrong marks");

  a_error_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_ERROR) |->
      (!out_first_of_frame && !out_last_of_frame && out_body_byte == 8'd0))
    else $error("error result with marks or data");

  a_body_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == KIND_HEADER || out_kind == KIND_PAYLOAD)) |->
      (out_error_code == ERR_MAGIC))
    else $error("body result carries an error code");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_kind == KIND_ERROR) |=> out_empty)
    else $error("result after error");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_kind) && $stable(out_body_byte)
       && $stable(out_first_of_frame) && $stable(out_last_of_frame)
       && $stable(out_error_code)))
    else $error("stalled result changed");

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (.*);

`default_nettype wire

[test/length_prefixed_frame_decoder_test.sv]
`default_nettype none

module length_prefixed_frame_decoder_test;
  import lpfd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE = 6;
  localparam int RANDOM_BYTES = 500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_FRAME_MAGIC;
  logic [31:0] cfg_data = 32'h0;
  logic        in_full;
  logic        out_empty;
  logic [1:0]  out_kind;
  logic [7:0]  out_body_byte;
  logic        out_first_of_frame;
  logic        out_last_of_frame;
  logic [1:0]  out_error_code;
  logic        cfg_ready;

  length_prefixed_frame_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_body_byte      (out_body_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_error_code     (out_error_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies
  logic [31:0] reg_magic = RST_FRAME_MAGIC;
  logic [31:0] reg_version = RST_WIRE_VERSION;
  logic [31:0] reg_max_header = RST_MAX_HEADER;
  logic [31:0] reg_max_payload = RST_MAX_PAYLOAD;

  // deframer state
  lpfd_phase_t dec_phase = PH_PREFIX;
  logic [3:0]  dec_count = 4'd0;
  logic [31:0] dec_shift = 32'h0;
  logic        dec_magic_bad = 1'b0;
  logic        dec_version_bad = 1'b0;
  logic [31:0] dec_hdr_len = 32'h0;
  logic [31:0] dec_pay_len = 32'h0;
  logic [31:0] dec_left = 32'h0;
  logic        dec_first = 1'b0;

  lpfd_result_t pending_results[$];

  int  fail_count = 0;
  int  results_checked = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  empty_frames = 0;
  int  dropped_bytes = 0;
  int  idle_cycles = 0;
  bit  no_stall = 1'b0;
  logic [1:0] error_hit = ERR_MAGIC;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    lpfd_result_t r;
    logic failed;
    r = '0;
    failed = 1'b1;
    case (dec_phase)
      PH_HALTED: ;
      PH_HEADER, PH_PAYLOAD: begin
        r.kind = (dec_phase == PH_HEADER) ? KIND_HEADER : KIND_PAYLOAD;
        r.body_byte = b;
        r.first_of_frame = dec_first;
        dec_first = 1'b0;
        dec_left = dec_left - 32'd1;
        if (dec_left == 32'd0) begin
          if (dec_phase == PH_HEADER && dec_pay_len != 32'd0) begin
            dec_phase = PH_PAYLOAD;
            dec_left = dec_pay_len;
          end else begin
            dec_phase = PH_PREFIX;
            r.last_of_frame = 1'b1;
          end
        end
        pending_results = {pending_results, r};
      end
      default: begin
        dec_shift = {dec_shift[23:0], b};
        if (dec_count == POS_MAGIC) begin
          dec_magic_bad = (dec_shift != reg_magic);
        end else if (dec_count == POS_VERSION) begin
          dec_version_bad = (dec_shift != reg_version);
        end else if (dec_count == POS_HEADER) begin
          dec_hdr_len = dec_shift;
        end else if (dec_count == POS_PAYLOAD) begin
          dec_pay_len = dec_shift;
          dec_shift = 32'h0;
          r.kind = KIND_ERROR;
          if (dec_magic_bad) r.error_code = ERR_MAGIC;
          else if (dec_version_bad) r.error_code = ERR_VERSION;
          else if (dec_hdr_len > reg_max_header) r.error_code = ERR_HEADER;
          else if (dec_pay_len > reg_max_payload) r.error_code = ERR_PAYLOAD;
          else failed = 1'b0;
          dec_magic_bad = 1'b0;
          dec_version_bad = 1'b0;
          if (failed) begin
            dec_phase = PH_HALTED;
            pending_results = {pending_results, r};
          end else if (dec_hdr_len == 32'd0 && dec_pay_len == 32'd0) begin
            r = '0;
            r.kind = KIND_EMPTY;
            r.first_of_frame = 1'b1;
            r.last_of_frame = 1'b1;
            pending_results = {pending_results, r};
          end else begin
            dec_first = 1'b1;
            dec_phase = (dec_hdr_len != 32'd0) ? PH_HEADER : PH_PAYLOAD;
            dec_left = (dec_hdr_len != 32'd0) ? dec_hdr_len : dec_pay_len;
          end
        end
        dec_count = dec_count + 4'd1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    lpfd_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 8'(out_kind), 8'(want.kind));
        check_field("body_byte", out_body_byte, want.body_byte);
        check_field("first_of_frame", 8'(out_first_of_frame), 8'(want.first_of_frame));
        check_field("last_of_frame", 8'(out_last_of_frame), 8'(want.last_of_frame));
        check_field("error_code", 8'(out_error_code), 8'(want.error_code));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= no_stall || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!no_stall && $urandom_range(0, 99) < 12) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_MAGIC:  reg_magic = val;
      REG_WIRE_VERSION: reg_version = val;
      REG_MAX_HEADER:   reg_max_header = val;
      REG_MAX_PAYLOAD:  reg_max_payload = val;
    endcase
  endtask

  task automatic configure(input logic [31:0] m, v, h, p);
    wait_drained();
    write_reg(REG_FRAME_MAGIC, m);
    write_reg(REG_WIRE_VERSION, v);
    write_reg(REG_MAX_HEADER, h);
    write_reg(REG_MAX_PAYLOAD, p);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_prefix(input logic [31:0] m, v, h, p);
    logic [31:0] words [4];
    words = '{m, v, h, p};
    foreach (words[w])
      for (int i = 3; i >= 0; i--) push_byte(words[w][8*i +: 8]);
  endtask

  // extremes: body alternates 00/FF; pause_at: body index at which to drain first
  task automatic send_frame(input logic [31:0] h, p, input bit extremes,
                            input int pause_at);
    send_prefix(reg_magic, reg_version, h, p);
    for (int i = 0; i < int'(h + p); i++) begin
      if (i == pause_at) wait_drained();
      push_byte(extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
    end
    frames_sent++;
    if (h == 0 && p == 0) empty_frames++;
  endtask

  task automatic test_directed_frames();
    send_frame(0, 0, 1'b1, -1);
    send_frame(1, 0, 1'b1, -1);
    send_frame(0, 1, 1'b1, -1);
    send_frame(2, 2, 1'b1, 0);
  endtask

  task automatic test_register_settings();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_frame(0, 0, 1'b0, -1);
    configure(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_frame(3, 0, 1'b1, -1);
    configure($urandom, $urandom, 32'd5, 32'd7);
    send_frame(5, 7, 1'b0, -1);
    send_frame(0, 7, 1'b0, -1);
    send_frame(5, 0, 1'b0, -1);
    configure($urandom, $urandom, RST_MAX_HEADER, RST_MAX_PAYLOAD);
    send_frame(1, 1, 1'b0, -1);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 48));
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_length(input int sel, input logic [31:0] lim);
    logic [31:0] len;
    len = (sel < 80) ? 32'($urandom_range(0, 8)) : 32'($urandom_range(0, 48));
    return (len > lim) ? lim : len;
  endfunction

  task automatic test_random_stream();
    int start;
    int sel;
    logic [31:0] h, p;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      no_stall = (bytes_sent - start >= 250) && (bytes_sent - start < 450);
      if ($urandom_range(0, 7) == 0)
        configure($urandom_range(0, 3) == 0 ? 32'h0 : $urandom,
                  $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom,
                  pick_limit(), pick_limit());
      sel = $urandom_range(0, 99);
      h = (sel < 10) ? 32'h0 : pick_length(sel, reg_max_header);
      p = (sel < 10) ? 32'h0 : pick_length(sel, reg_max_payload);
      send_frame(h, p, 1'b0,
                 ($urandom_range(0, 19) == 0 && h + p > 0) ?
                 $urandom_range(0, h + p - 1) : -1);
    end
    no_stall = 1'b0;
  endtask

  // an error halts the block until reset, so this must come last
  task automatic test_error_halt();
    logic [31:0] m, v, h, p;
    error_hit = 2'($urandom_range(0, 3));
    configure($urandom, $urandom, $urandom_range(0, 64), $urandom_range(0, 64));
    m = reg_magic;
    v = reg_version;
    h = $urandom_range(0, reg_max_header);
    p = $urandom_range(0, reg_max_payload);
    case (error_hit)
      ERR_MAGIC: begin
        m = m ^ (32'h1 << $urandom_range(0, 31));
        if ($urandom_range(0, 1)) v = ~v;
      end
      ERR_VERSION: v = v ^ (32'h1 << $urandom_range(0, 31));
      ERR_HEADER:  begin
        h = 32'h8000_0000 | $urandom;
        if ($urandom_range(0, 1)) p = 32'h8000_0000 | $urandom;
      end
      ERR_PAYLOAD: p = 32'h8000_0000 | $urandom;
    endcase
    send_prefix(m, v, h, p);
    frames_sent++;
    repeat (40) begin
      push_byte(8'($urandom_range(0, 255)));
      dropped_bytes++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_register_settings();
    test_random_stream();
    test_error_halt();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d frames (%0d empty), %0d bytes in, %0d results checked",
             frames_sent, empty_frames, bytes_sent, results_checked);
    $display("stream closed by error code %0d, then %0d bytes dropped while halted",
             error_hit, dropped_bytes);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/lpfd_pkg.sv
rtl/lpfd_front.sv
rtl/lpfd_queue.sv
rtl/lpfd_back.sv
rtl/length_prefixed_frame_decoder.sv
rtl/lpfd_checker.sv
test/length_prefixed_frame_decoder_test.sv
